>>> hw/rtl/sofdfr_pkg.sv
// ----------------------------------------------------------------------------
// sofdfr_pkg
// Shared types and constants of the start-of-frame / length / xor deframer.
// ----------------------------------------------------------------------------
package sofdfr_pkg;

  // apb address width: one register at byte address 0, index in bit 2
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register indexes
  localparam logic RegSof = 1'b0;

  // reset value of the start-of-frame register
  localparam logic [7:0] SofReset = 8'hFE;

  // frame bytes besides the data: length, two command bytes, check
  localparam logic [8:0] FrameOverhead = 9'd4;

  // deframer phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  // one result item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       is_last;
    logic       frame_good;
  } result_t;

endpackage

>>> hw/rtl/sof_length_xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// sof_length_xor_frame_deframer
// Hunts for the start byte, reads the length and passes each frame byte on
// with its index; the check byte is marked last with the xor check result.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | sink      | in_valid_i / in_stall_o   | rx_byte_i
//   out     | source    | out_valid_o / out_stall_i | frame_byte_o, byte_index_o,
//           |           |                           | is_last_o, frame_good_o
//   cfg     | apb slave | psel, penable, pready     | paddr, pwdata, prdata
//
// One byte per cycle while the output does not stall: an input register feeds
// the per-byte state update, whose result lands in the output register and
// transfers out from there.
// Reset (asynchronous, active low) empties both registers and starts hunting.
// A stalled output holds its register; the input register still takes one
// more byte, then the input stalls until the output moves.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   frame_byte_o,
  output logic [8:0]                   byte_index_o,
  output logic                         is_last_o,
  output logic                         frame_good_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sofdfr_pkg::AddrW-1:0] paddr,
  input  logic [sofdfr_pkg::DataW-1:0] pwdata,
  output logic [sofdfr_pkg::DataW-1:0] prdata,
  output logic                         pready
);
  import sofdfr_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_load;
  logic       fire;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  result_t    step_res;
  logic       step_valid;
  logic [7:0] sof;

  // configuration registers
  sofdfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sof_o   (sof)
  );

  // a byte is processed when the output register is free or being emptied
  assign fire       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~fire;
  assign in_load    = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_load | (in_valid_q & ~fire);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // per-byte frame update
  sofdfr_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .sof_i       (sof),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // output register
  assign out_valid_d = fire ? step_valid : (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire & step_valid) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_res_q.frame_byte;
  assign byte_index_o = out_res_q.byte_index;
  assign is_last_o    = out_res_q.is_last;
  assign frame_good_o = out_res_q.frame_good;

endmodule

>>> hw/rtl/sofdfr_cfg.sv
// ----------------------------------------------------------------------------
// sofdfr_cfg
// APB register block holding the start-of-frame byte value.
// ----------------------------------------------------------------------------
module sofdfr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sofdfr_pkg::AddrW-1:0] paddr,
  input  logic [sofdfr_pkg::DataW-1:0] pwdata,
  output logic [sofdfr_pkg::DataW-1:0] prdata,
  output logic                         pready,
  output logic [7:0]                   sof_o
);
  import sofdfr_pkg::*;

  logic [7:0] sof_q;
  logic       wr_en;

  // write strobe on the access cycle
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == RegSof);

  // start-of-frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q <= SofReset;
    end else if (wr_en) begin
      sof_q <= pwdata[7:0];
    end
  end

  // read mux, unused addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegSof) begin
      prdata = {{(DataW-8){1'b0}}, sof_q};
    end
  end

  assign sof_o = sof_q;

endmodule

>>> hw/rtl/sofdfr_step.sv
// ----------------------------------------------------------------------------
// sofdfr_step
// Frame tracking state and the per-byte update producing one result.
// ----------------------------------------------------------------------------
module sofdfr_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          sof_i,
  output logic                res_valid_o,
  output sofdfr_pkg::result_t res_o
);
  import sofdfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [8:0] rem_q, rem_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic [8:0] rem_dec;
  logic [7:0] xor_acc;
  logic       body_last;

  assign rem_dec   = rem_q - 9'd1;
  assign xor_acc   = xor_q ^ byte_i;
  assign body_last = (rem_dec == 9'd0);

  // next state
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    xor_d   = xor_q;
    case (phase_q)
      PH_LEN: begin
        xor_d   = byte_i;
        rem_d   = {1'b0, byte_i} + FrameOverhead - 9'd1;
        pos_d   = 9'd1;
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        xor_d = xor_acc;
        rem_d = rem_dec;
        pos_d = pos_q + 9'd1;
        if (body_last) begin
          phase_d = PH_HUNT;
          pos_d   = 9'd0;
          xor_d   = 8'd0;
        end
      end
      default: begin
        // hunting, and the unused phase code
        phase_d = PH_HUNT;
        if (byte_i == sof_i) begin
          phase_d = PH_LEN;
          pos_d   = 9'd0;
          xor_d   = 8'd0;
          rem_d   = 9'd0;
        end
      end
    endcase
  end

  // result for the byte being processed
  always_comb begin
    res_valid_o      = 1'b0;
    res_o.frame_byte = byte_i;
    res_o.byte_index = 9'd0;
    res_o.is_last    = 1'b0;
    res_o.frame_good = 1'b0;
    case (phase_q)
      PH_LEN: begin
        res_valid_o = fire_i;
      end
      PH_BODY: begin
        res_valid_o      = fire_i;
        res_o.byte_index = pos_q;
        res_o.is_last    = body_last;
        res_o.frame_good = body_last & (xor_acc == 8'd0);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  // state registers advance once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      rem_q   <= 9'd0;
      pos_q   <= 9'd0;
      xor_q   <= 8'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

endmodule

>>> hw/rtl/sofdfr_checker.sv
// ----------------------------------------------------------------------------
// sofdfr_sva
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module sofdfr_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic [8:0] byte_index_o,
  input logic       is_last_o,
  input logic       frame_good_o
);

  // a stalled result holds until it is transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o)
      && $stable(byte_index_o) && $stable(is_last_o) && $stable(frame_good_o))
    else $error("stalled result changed");

  // the good flag only comes with the check byte
  a_good_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_good_o |-> is_last_o)
    else $error("frame_good without is_last");

  // index never runs past the longest frame
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_index_o <= 9'd258)
    else $error("byte index out of range");

  // the length byte never ends a frame
  a_len_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_index_o == 9'd0) |-> !is_last_o)
    else $error("length byte marked last");

endmodule

bind sof_length_xor_frame_deframer sofdfr_sva u_sofdfr_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .byte_index_o (byte_index_o),
  .is_last_o    (is_last_o),
  .frame_good_o (frame_good_o)
);
